// File: hw/rtl/mvmh_pkg.sv
// package with shared types, codes and defaults of the missing-value marginal histogram
package mvmh_pkg;

  localparam int MAX_DIMS = 4;
  localparam int HW_DIMS = (MAX_DIMS < 4) ? MAX_DIMS : 4;
  localparam int BIN_DEPTH_DEF = 4096;
  localparam int COUNT_BITS_DEF = 32;

  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ELEMENT_KIND  = 3'd0,
    REG_IN_DIMS_USED  = 3'd1,
    REG_IN_SIZE_A     = 3'd2,
    REG_IN_SIZE_B     = 3'd3,
    REG_IN_SIZE_C     = 3'd4,
    REG_IN_SIZE_D     = 3'd5,
    REG_OUT_DIMS_USED = 3'd6,
    REG_DIM_SELECT    = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    REQ_ELEMENT = 2'd0,
    REQ_READ    = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_INTEGER = 2'd0,
    KIND_DOUBLE  = 2'd1,
    KIND_STRING  = 2'd2,
    KIND_NONE    = 2'd3
  } element_kind_t;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_TERM   = 9'b000001000,
    S_ACC    = 9'b000010000,
    S_PSTEP  = 9'b000100000,
    S_LOOKUP = 9'b001000000,
    S_MODIFY = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

endpackage

// File: hw/rtl/mvmh_ram.sv
// generic single-write, single-read ram with registered read data
module mvmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/missing_value_marginal_histogram.sv
// top level of the missing-value marginal histogram
// Usage: after reset the bin store is swept to zero, one bin per cycle; no item is
// taken meanwhile, configuration writes are. An item is then handled one at a time
// by a sequencer around a shared restoring divider and one shared multiplier. A
// read looks the bin up and returns its count, a clear looks it up and zeroes it,
// and an element that is not missing or an unused request goes straight to the
// result. A missing element runs the divider for each input dimension whose extent
// is above one (one bit of the divider per cycle), skips each other dimension of
// the four, does two multiplies and an update for each kept output dimension, then,
// unless the bin is dropped, the read-modify-write on the single ram, and presents
// the result, which waits while the output is not taken. Registers are written
// through the cfg port; the user must write them only while no item is in flight,
// as the block itself does not enforce it.
module missing_value_marginal_histogram #(
  parameter int BIN_DEPTH = mvmh_pkg::BIN_DEPTH_DEF,
  parameter int COUNT_BITS = mvmh_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // fields from bit 0: element_value[63:0], string_is_na[64], bin_index[76:65], zero fill
  input  logic [mvmh_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // fields from bit 0: req_type[1:0]
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: element_missing[0], bin_dropped[1], bin_touched[13:2],
  // bin_value[45:14], zero fill
  output logic [mvmh_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvmh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mvmh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mvmh_pkg::*;

  localparam int PW = $clog2(BIN_DEPTH);
  localparam int PRODW = 16 + PW;
  localparam int SUMW = PRODW + 1;
  localparam logic [PRODW-1:0] DEPTH_PROD = PRODW'(BIN_DEPTH);
  localparam logic [SUMW-1:0] DEPTH_SUM = SUMW'(BIN_DEPTH);
  localparam logic [16:0] DEPTH_IDX = 17'(BIN_DEPTH);
  localparam logic [PW-1:0] LAST_BIN = PW'(BIN_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [2:0] HW_DIMS_L = 3'(HW_DIMS);

  // configuration registers
  logic [1:0]  element_kind;
  logic [2:0]  in_dims_used;
  logic [15:0] in_size [4];
  logic [2:0]  out_dims_used;
  logic [7:0]  dim_select;

  state_t            state;
  logic [31:0]       element_position;
  logic [PW-1:0]     clr_addr;
  req_type_t         req;
  logic [31:0]       q;
  logic [15:0]       rem;
  logic [4:0]        bit_cnt;
  logic [1:0]        dim_j;
  logic [15:0]       idx [4];
  logic [1:0]        dim_k;
  logic [PW-1:0]     bin;
  logic [PW-1:0]     p;
  logic              p_big;
  logic              over;
  logic [PRODW-1:0]  prod;
  logic              res_missing;
  logic              res_dropped;
  logic [11:0]       res_touched;
  logic [31:0]       res_value;

  logic                  ram_we;
  logic [PW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  function automatic logic [2:0] clamp_dims(input logic [2:0] n);
    logic [2:0] r;
    r = n;
    if (n == 3'd0) begin
      r = 3'd1;
    end else if (n > HW_DIMS_L) begin
      r = HW_DIMS_L;
    end
    return r;
  endfunction

  logic [2:0] nin;
  logic [2:0] nout;
  assign nin = clamp_dims(in_dims_used);
  assign nout = clamp_dims(out_dims_used);

  function automatic logic [15:0] extent_of(input logic [1:0] d, input logic [2:0] n,
                                            input logic [15:0] sz);
    logic [15:0] r;
    r = sz;
    if ({1'b0, d} >= n || sz == 16'd0) begin
      r = 16'd1;
    end
    return r;
  endfunction

  // input fields
  logic [63:0] in_value;
  logic        in_string_na;
  logic [11:0] in_bin_index;
  logic        in_missing;
  assign in_value = s_axis_tdata[63:0];
  assign in_string_na = s_axis_tdata[64];
  assign in_bin_index = s_axis_tdata[76:65];

  always_comb begin
    unique case (element_kind_t'(element_kind))
      KIND_INTEGER: in_missing = (in_value[31:0] == 32'h8000_0000);
      KIND_DOUBLE:  in_missing = (&in_value[62:52]) && (in_value[51:0] != 52'd0);
      KIND_STRING:  in_missing = in_string_na;
      default:      in_missing = 1'b0;
    endcase
  end

  // divider step
  logic [15:0] div_m;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [15:0] rem_next;
  assign div_m = extent_of(dim_j, nin, in_size[dim_j]);
  assign rem_sh = {rem, q[31]};
  assign rem_ge = rem_sh >= {1'b0, div_m};
  assign rem_next = rem_ge ? 16'(rem_sh - {1'b0, div_m}) : rem_sh[15:0];

  // recompose: selected dimension and shared multiplier
  logic [1:0]       sel;
  logic [15:0]      sel_m;
  logic [15:0]      sel_i;
  logic [15:0]      mul_a;
  logic [PRODW-1:0] mul_y;
  logic [SUMW-1:0]  bin_sum;
  assign sel = dim_select[2*dim_k +: 2];
  assign sel_m = extent_of(sel, nin, in_size[sel]);
  assign sel_i = ({1'b0, sel} < nin) ? idx[sel] : 16'd0;
  assign mul_a = (state == S_TERM) ? sel_i : sel_m;
  assign mul_y = PRODW'(mul_a) * PRODW'(p);
  assign bin_sum = SUMW'(bin) + SUMW'(prod);

  logic [COUNT_BITS-1:0] count_inc;
  assign count_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

  logic in_fire;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = bin;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
      end
      S_LOOKUP: begin
        ram_we = (req == REQ_CLEAR) && !over;
      end
      S_MODIFY: begin
        ram_we = (req == REQ_ELEMENT);
        ram_wdata = count_inc;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mvmh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BIN_DEPTH)
  ) u_bins (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(bin),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      element_kind <= KIND_INTEGER;
      in_dims_used <= 3'd1;
      in_size[0] <= 16'd1;
      in_size[1] <= 16'd1;
      in_size[2] <= 16'd1;
      in_size[3] <= 16'd1;
      out_dims_used <= 3'd1;
      dim_select <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_ELEMENT_KIND:  element_kind <= cfg_data[1:0];
        REG_IN_DIMS_USED:  in_dims_used <= cfg_data[2:0];
        REG_IN_SIZE_A:     in_size[0] <= cfg_data;
        REG_IN_SIZE_B:     in_size[1] <= cfg_data;
        REG_IN_SIZE_C:     in_size[2] <= cfg_data;
        REG_IN_SIZE_D:     in_size[3] <= cfg_data;
        REG_OUT_DIMS_USED: out_dims_used <= cfg_data[2:0];
        REG_DIM_SELECT:    dim_select <= cfg_data[7:0];
        default:           dim_select <= dim_select;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      element_position <= 32'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_BIN) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            req <= req_type_t'(s_axis_tuser);
            q <= element_position;
            rem <= 16'd0;
            bit_cnt <= 5'd0;
            dim_j <= 2'd0;
            res_missing <= (req_type_t'(s_axis_tuser) == REQ_ELEMENT) && in_missing;
            res_dropped <= 1'b0;
            res_touched <= 12'd0;
            res_value <= 32'd0;
            bin <= PW'(in_bin_index);
            over <= ({5'd0, in_bin_index} >= DEPTH_IDX);
            unique case (req_type_t'(s_axis_tuser))
              REQ_ELEMENT: begin
                element_position <= s_axis_tlast ? 32'd0 : element_position + 32'd1;
                state <= in_missing ? S_DIV : S_DONE;
              end
              REQ_READ, REQ_CLEAR: state <= S_LOOKUP;
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_m == 16'd1 || bit_cnt == 5'd31) begin
            idx[dim_j] <= (div_m == 16'd1) ? 16'd0 : rem_next;
            rem <= 16'd0;
            bit_cnt <= 5'd0;
            if (div_m != 16'd1) begin
              q <= {q[30:0], rem_ge};
            end
            dim_j <= dim_j + 1'b1;
            if (dim_j == 2'd3) begin
              dim_k <= 2'd0;
              bin <= '0;
              p <= PW'(1);
              p_big <= 1'b0;
              over <= 1'b0;
              state <= S_TERM;
            end
          end else begin
            rem <= rem_next;
            q <= {q[30:0], rem_ge};
            bit_cnt <= bit_cnt + 1'b1;
          end
        end
        S_TERM: begin
          prod <= mul_y;
          state <= S_ACC;
        end
        S_ACC: begin
          if ((p_big && sel_i != 16'd0) || bin_sum >= DEPTH_SUM) begin
            over <= 1'b1;
          end else begin
            bin <= bin_sum[PW-1:0];
          end
          prod <= mul_y;
          state <= S_PSTEP;
        end
        S_PSTEP: begin
          if (!p_big) begin
            if (prod >= DEPTH_PROD) begin
              p_big <= 1'b1;
            end else begin
              p <= prod[PW-1:0];
            end
          end
          if ({1'b0, dim_k} == nout - 3'd1) begin
            state <= S_LOOKUP;
          end else begin
            dim_k <= dim_k + 1'b1;
            state <= S_TERM;
          end
        end
        S_LOOKUP: begin
          if (over) begin
            res_dropped <= 1'b1;
            state <= S_DONE;
          end else if (req == REQ_CLEAR) begin
            res_touched <= 12'(bin);
            state <= S_DONE;
          end else begin
            state <= S_MODIFY;
          end
        end
        S_MODIFY: begin
          res_touched <= 12'(bin);
          res_value <= (req == REQ_ELEMENT) ? 32'(count_inc) : 32'(ram_rdata);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {2'b00, res_value, res_touched, res_dropped, res_missing};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
